@@ src/stt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package stt_pkg;

	localparam int KW_MAX_LEN  = 8;
	localparam int OFFSET_BITS = 32;
	localparam int COUNT_BITS  = 16;
	localparam int KW_COUNT    = 41;
	localparam int MAX_TOKENS  = 3;

	localparam logic [6:0] K_EOF      = 7'd0;
	localparam logic [6:0] K_ERROR    = 7'd1;
	localparam logic [6:0] K_IDENT    = 7'd2;
	localparam logic [6:0] K_NUMBER   = 7'd3;
	localparam logic [6:0] K_STRING   = 7'd4;
	localparam logic [6:0] K_LPAREN   = 7'd5;
	localparam logic [6:0] K_RPAREN   = 7'd6;
	localparam logic [6:0] K_LBRACE   = 7'd7;
	localparam logic [6:0] K_RBRACE   = 7'd8;
	localparam logic [6:0] K_LBRACKET = 7'd9;
	localparam logic [6:0] K_RBRACKET = 7'd10;
	localparam logic [6:0] K_COMMA    = 7'd11;
	localparam logic [6:0] K_DOT      = 7'd12;
	localparam logic [6:0] K_SEMI     = 7'd13;
	localparam logic [6:0] K_COLON    = 7'd14;
	localparam logic [6:0] K_PLUS     = 7'd15;
	localparam logic [6:0] K_MINUS    = 7'd16;
	localparam logic [6:0] K_STAR     = 7'd17;
	localparam logic [6:0] K_SLASH    = 7'd18;
	localparam logic [6:0] K_ASSIGN   = 7'd19;
	localparam logic [6:0] K_EQ       = 7'd20;
	localparam logic [6:0] K_ARROW    = 7'd21;
	localparam logic [6:0] K_NEQ      = 7'd22;
	localparam logic [6:0] K_LT       = 7'd23;
	localparam logic [6:0] K_LTE      = 7'd24;
	localparam logic [6:0] K_GT       = 7'd25;
	localparam logic [6:0] K_GTE      = 7'd26;
	localparam logic [6:0] K_FIRST_KW = 7'd27;

	localparam logic [1:0] E_NONE     = 2'd0;
	localparam logic [1:0] E_UNTERM   = 2'd1;
	localparam logic [1:0] E_BANG     = 2'd2;
	localparam logic [1:0] E_BADBYTE  = 2'd3;

	localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
		"in", "let", "mut", "fun", "for", "nil", "enum", "type", "else", "when",
		"is", "not", "do", "pub", "i8", "f8", "while", "break", "async", "await",
		"i16", "f16", "return", "struct", "elif", "i32", "i64", "f32", "f64",
		"default", "list", "bool", "continue", "dyn", "num", "str", "map", "set",
		"void", "use", "as"
	};
	localparam int KW_LEN [KW_COUNT] = '{
		2, 3, 3, 3, 3, 3, 4, 4, 4, 4, 2, 3, 2, 3, 2, 2, 5, 5, 5, 5, 3, 3, 6, 6, 4,
		3, 3, 3, 3, 7, 4, 4, 8, 3, 3, 3, 3, 3, 4, 3, 2
	};

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_text;
	} char_t;

	typedef struct packed {
		logic [6:0]             token_kind;
		logic [1:0]             error_kind;
		logic [OFFSET_BITS-1:0] start_offset;
		logic [COUNT_BITS-1:0]  token_length;
		logic [COUNT_BITS-1:0]  line_number;
		logic [COUNT_BITS-1:0]  column_number;
		logic                   last_of_run;
	} token_t;

	typedef struct packed {
		logic [1:0]                  count;
		token_t [MAX_TOKENS-1:0]     tok;
	} bundle_t;

	typedef logic [KW_MAX_LEN-1:0][7:0] prefix_t;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		sat_inc = (v == {COUNT_BITS{1'b1}}) ? v : v + COUNT_BITS'(1);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = (c >= "0" && c <= "9");
	endfunction

	function automatic logic [6:0] single_symbol(input logic [7:0] c);
		unique case (c)
			"(": single_symbol = K_LPAREN;
			")": single_symbol = K_RPAREN;
			"{": single_symbol = K_LBRACE;
			"}": single_symbol = K_RBRACE;
			"[": single_symbol = K_LBRACKET;
			"]": single_symbol = K_RBRACKET;
			",": single_symbol = K_COMMA;
			".": single_symbol = K_DOT;
			";": single_symbol = K_SEMI;
			":": single_symbol = K_COLON;
			"+": single_symbol = K_PLUS;
			"-": single_symbol = K_MINUS;
			"*": single_symbol = K_STAR;
			default: single_symbol = K_EOF;
		endcase
	endfunction

	// parallel compare of the stored prefix against every keyword of matching length
	function automatic logic [6:0] kw_kind(input prefix_t pref, input logic [COUNT_BITS-1:0] len);
		logic [8*KW_MAX_LEN-1:0] w;
		logic [6:0]              kind;
		kind = K_IDENT;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			w = '0;
			for (int j = 0; j < KW_MAX_LEN; j++) begin
				if (j < KW_LEN[i])
					w = {w[8*KW_MAX_LEN-9:0], pref[j]};
			end
			if (len == COUNT_BITS'(KW_LEN[i]) && w == KW_TEXT[i])
				kind = 7'(K_FIRST_KW + 7'(i));
		end
		kw_kind = kind;
	endfunction

endpackage
`default_nettype wire

@@ src/source_text_tokenizer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Streaming tokenizer: one source byte per beat, accepted every cycle while the
// result buffer is empty or its last token leaves. A byte yields zero to three
// tokens, computed combinationally from the scan state and loaded into a
// three-entry result buffer; tokens leave one per cycle while tok_stall is low,
// so a byte with several tokens holds the input. Keyword lookup is parallel.
module source_text_tokenizer_unit import stt_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   char_valid,
	output logic        char_stall,
	input  wire char_t  char_beat,
	output logic        tok_valid,
	input  wire logic   tok_stall,
	output token_t      tok_beat
);

	bundle_t                  res;
	token_t [MAX_TOKENS-1:0]  buf_q;
	logic [1:0]               cnt_q, idx_q;
	logic                     take, out_take;

	assign tok_valid  = (idx_q < cnt_q);
	assign out_take   = tok_valid && !tok_stall;
	// room once the buffer is empty or its last beat leaves this cycle
	assign char_stall = tok_valid && !(out_take && (idx_q + 2'd1 == cnt_q));
	assign take       = char_valid && !char_stall;
	assign tok_beat   = buf_q[idx_q];

	stt_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.beat    (char_beat),
		.results (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (take) begin
			cnt_q <= res.count;
			idx_q <= '0;
		end else if (out_take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			buf_q <= res.tok;
	end

endmodule
`default_nettype wire

@@ src/stt_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none
module stt_scan import stt_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    take,
	input  wire char_t   beat,
	output bundle_t      results
);

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_NUMBER, M_NUMDOT, M_FRACTION, M_STRING,
		M_SLASH, M_COMMENT, M_EQUAL, M_BANG, M_LESS, M_GREATER
	} mode_t;

	mode_t                  mode_q, mode_n;
	prefix_t                pref_q, pref_n;
	logic [OFFSET_BITS-1:0] start_q, start_n, pos_q, pos_n, dot_at;
	logic [COUNT_BITS-1:0]  run_q, run_n, line_q, line_n, col_q, col_n;
	logic [7:0]             c;
	logic                   fin, used;
	logic [1:0]             cnt;
	token_t [MAX_TOKENS-1:0] res;
	logic [6:0]             sym;

	function automatic token_t mk(input logic [6:0] k, input logic [1:0] e,
			input logic [OFFSET_BITS-1:0] s, input logic [COUNT_BITS-1:0] l,
			input logic [COUNT_BITS-1:0] ln, input logic [COUNT_BITS-1:0] cl);
		token_t t;
		t.token_kind    = k;
		t.error_kind    = e;
		t.start_offset  = s;
		t.token_length  = l;
		t.line_number   = ln;
		t.column_number = cl;
		t.last_of_run   = 1'b0;
		mk = t;
	endfunction

	always_comb begin
		c      = beat.char_code;
		fin    = beat.end_of_text || (c == 8'd0);
		mode_n = mode_q;
		pref_n = pref_q;
		start_n = start_q;
		pos_n  = pos_q;
		run_n  = run_q;
		line_n = line_q;
		col_n  = col_q;
		used   = 1'b0;
		cnt    = 2'd0;
		res    = '0;
		dot_at = '0;
		sym    = K_EOF;

		unique case (mode_q)
			M_IDENT: begin
				if (!fin && (is_alpha(c) || is_digit(c) || c == "_")) begin
					if (run_n < COUNT_BITS'(KW_MAX_LEN))
						pref_n[run_n[$clog2(KW_MAX_LEN)-1:0]] = c;
					pos_n = pos_n + OFFSET_BITS'(1); col_n = sat_inc(col_n);
					run_n = sat_inc(run_n);
					used = 1'b1;
				end else begin
					res[cnt] = mk(kw_kind(pref_n, run_n), E_NONE, start_n, run_n, line_n, col_n);
					cnt = cnt + 2'd1;
				end
			end
			M_NUMBER: begin
				if (!fin && is_digit(c)) begin
					pos_n = pos_n + OFFSET_BITS'(1); col_n = sat_inc(col_n);
					run_n = sat_inc(run_n);
					used = 1'b1;
				end else if (!fin && c == ".") begin
					mode_n = M_NUMDOT;
					used = 1'b1;
				end else begin
					res[cnt] = mk(K_NUMBER, E_NONE, start_n, run_n, line_n, col_n);
					cnt = cnt + 2'd1;
				end
			end
			M_NUMDOT: begin
				if (!fin && is_digit(c)) begin
					// dot and digit both join the number
					pos_n = pos_n + OFFSET_BITS'(2);
					col_n = sat_inc(sat_inc(col_n));
					run_n = sat_inc(sat_inc(run_n));
					mode_n = M_FRACTION;
					used = 1'b1;
				end else begin
					res[cnt] = mk(K_NUMBER, E_NONE, start_n, run_n, line_n, col_n);
					cnt = cnt + 2'd1;
					dot_at = pos_n;
					pos_n = pos_n + OFFSET_BITS'(1); col_n = sat_inc(col_n);
					res[cnt] = mk(K_DOT, E_NONE, dot_at, COUNT_BITS'(1), line_n, col_n);
					cnt = cnt + 2'd1;
				end
			end
			M_FRACTION: begin
				if (!fin && is_digit(c)) begin
					pos_n = pos_n + OFFSET_BITS'(1); col_n = sat_inc(col_n);
					run_n = sat_inc(run_n);
					used = 1'b1;
				end else begin
					res[cnt] = mk(K_NUMBER, E_NONE, start_n, run_n, line_n, col_n);
					cnt = cnt + 2'd1;
				end
			end
			M_STRING: begin
				if (fin) begin
					res[cnt] = mk(K_ERROR, E_UNTERM, start_n, '0, line_n, col_n);
					cnt = cnt + 2'd1;
				end else begin
					if (c == 8'h0A)
						line_n = sat_inc(line_n);
					pos_n = pos_n + OFFSET_BITS'(1); col_n = sat_inc(col_n);
					run_n = sat_inc(run_n);
					used = 1'b1;
					if (c == "\"") begin
						res[cnt] = mk(K_STRING, E_NONE, start_n, run_n, line_n, col_n);
						cnt = cnt + 2'd1;
						mode_n = M_IDLE;
					end
				end
			end
			M_SLASH: begin
				if (!fin && c == "/") begin
					pos_n = pos_n + OFFSET_BITS'(1); col_n = sat_inc(col_n);
					mode_n = M_COMMENT;
					used = 1'b1;
				end else begin
					res[cnt] = mk(K_SLASH, E_NONE, start_n, run_n, line_n, col_n);
					cnt = cnt + 2'd1;
				end
			end
			M_COMMENT: begin
				if (!fin && c != 8'h0A) begin
					pos_n = pos_n + OFFSET_BITS'(1); col_n = sat_inc(col_n);
					used = 1'b1;
				end
			end
			M_EQUAL: begin
				if (!fin && (c == "=" || c == ">")) begin
					pos_n = pos_n + OFFSET_BITS'(1); col_n = sat_inc(col_n);
					run_n = sat_inc(run_n);
					res[cnt] = mk((c == "=") ? K_EQ : K_ARROW, E_NONE, start_n, run_n,
						line_n, col_n);
					cnt = cnt + 2'd1;
					mode_n = M_IDLE;
					used = 1'b1;
				end else begin
					res[cnt] = mk(K_ASSIGN, E_NONE, start_n, run_n, line_n, col_n);
					cnt = cnt + 2'd1;
				end
			end
			M_BANG: begin
				if (!fin && c == "=") begin
					pos_n = pos_n + OFFSET_BITS'(1); col_n = sat_inc(col_n);
					run_n = sat_inc(run_n);
					res[cnt] = mk(K_NEQ, E_NONE, start_n, run_n, line_n, col_n);
					cnt = cnt + 2'd1;
					mode_n = M_IDLE;
					used = 1'b1;
				end else begin
					res[cnt] = mk(K_ERROR, E_BANG, start_n, '0, line_n, col_n);
					cnt = cnt + 2'd1;
				end
			end
			M_LESS, M_GREATER: begin
				if (!fin && c == "=") begin
					pos_n = pos_n + OFFSET_BITS'(1); col_n = sat_inc(col_n);
					run_n = sat_inc(run_n);
					res[cnt] = mk((mode_q == M_LESS) ? K_LTE : K_GTE, E_NONE, start_n, run_n,
						line_n, col_n);
					cnt = cnt + 2'd1;
					mode_n = M_IDLE;
					used = 1'b1;
				end else begin
					res[cnt] = mk((mode_q == M_LESS) ? K_LT : K_GT, E_NONE, start_n, run_n,
						line_n, col_n);
					cnt = cnt + 2'd1;
				end
			end
			default: ;
		endcase
		if (!used)
			mode_n = M_IDLE;

		// byte not taken by a pending token is skipped as whitespace or starts a fresh one
		if (!used && !fin) begin
			if (c == " " || c == 8'h0D || c == 8'h09) begin
				pos_n = pos_n + OFFSET_BITS'(1); col_n = sat_inc(col_n);
			end else if (c == 8'h0A) begin
				line_n = sat_inc(line_n);
				pos_n = pos_n + OFFSET_BITS'(1); col_n = COUNT_BITS'(1);
			end else begin
				start_n = pos_n;
				pos_n = pos_n + OFFSET_BITS'(1); col_n = sat_inc(col_n);
				run_n = COUNT_BITS'(1);
				sym = single_symbol(c);
				if (is_alpha(c) || c == "_") begin
					pref_n[0] = c;
					mode_n = M_IDENT;
				end else if (is_digit(c)) begin
					mode_n = M_NUMBER;
				end else begin
					unique case (c)
						"\"": mode_n = M_STRING;
						"/": mode_n = M_SLASH;
						"=": mode_n = M_EQUAL;
						"!": mode_n = M_BANG;
						"<": mode_n = M_LESS;
						">": mode_n = M_GREATER;
						default: begin
							if (sym != K_EOF)
								res[cnt] = mk(sym, E_NONE, start_n, run_n, line_n, col_n);
							else
								res[cnt] = mk(K_ERROR, E_BADBYTE, start_n, '0, line_n, col_n);
							cnt = cnt + 2'd1;
						end
					endcase
				end
			end
		end

		if (fin) begin
			res[cnt] = mk(K_EOF, E_NONE, pos_n, '0, line_n, col_n);
			cnt = cnt + 2'd1;
			mode_n  = M_IDLE;
			pref_n  = '0;
			start_n = '0;
			pos_n   = '0;
			run_n   = '0;
			line_n  = COUNT_BITS'(1);
			col_n   = '0;
		end
		if (cnt != 2'd0)
			res[cnt - 2'd1].last_of_run = 1'b1;

		results.count = cnt;
		results.tok   = res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pref_q  <= '0;
			start_q <= '0;
			pos_q   <= '0;
			run_q   <= '0;
			line_q  <= COUNT_BITS'(1);
			col_q   <= '0;
		end else if (take) begin
			mode_q  <= mode_n;
			pref_q  <= pref_n;
			start_q <= start_n;
			pos_q   <= pos_n;
			run_q   <= run_n;
			line_q  <= line_n;
			col_q   <= col_n;
		end
	end

endmodule
`default_nettype wire
